### rtl/size_budget_lru_cache_unit_macros.svh
// Assertion macros for the size-budgeted cache table.
`ifndef SIZE_BUDGET_LRU_CACHE_UNIT_MACROS_SVH
`define SIZE_BUDGET_LRU_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache table assertion failed");

// Next-cycle implication, checked outside reset.
`define SBLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache table assertion failed");

`endif

### rtl/sblc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sblc_pkg;
  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);

  localparam int KEY_W = 32;
  localparam int SIZE_W = 24;
  localparam int TOTAL_W = 31;
  localparam int STAMP_W = 32;

  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 88;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TRIM = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_BYTE_LIMIT = 2'd0;
  localparam logic [1:0] REG_CACHE_ENABLED = 2'd1;
  localparam logic [1:0] REG_UNLIMITED = 2'd2;

  // Event codes
  localparam logic [2:0] EV_ADDED = 3'd0;
  localparam logic [2:0] EV_REFRESHED = 3'd1;
  localparam logic [2:0] EV_REJECTED = 3'd2;
  localparam logic [2:0] EV_EVICTED = 3'd3;
  localparam logic [2:0] EV_REMOVED = 3'd4;
  localparam logic [2:0] EV_NOT_FOUND = 3'd5;
  localparam logic [2:0] EV_FLUSHED = 3'd6;
endpackage
`default_nettype wire

### rtl/size_budget_lru_cache_unit.sv
// A lookup scans every slot of the table, then the result is emitted.
// Each eviction rescans the table for the oldest stamp, and an insert adds one
// free-slot scan. The unit takes one item at a time; it has a single age compare
// unit and a one-port table read. Reset (rst, synchronous) empties the table, clears
// the use clock and total, and loads byte_limit 0, cache_enabled 1, unlimited 0.
`timescale 1ns / 1ps
`default_nettype none
`include "size_budget_lru_cache_unit_macros.svh"
module size_budget_lru_cache_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // item_key [31:0], item_size [55:32]
  input  wire logic [sblc_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation [1:0]
  input  wire logic [1:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // event_key [31:0], event_size [55:32], total_size [86:56], zero [87]
  output logic [sblc_pkg::OUT_DATA_W-1:0]      m_tdata,
  // event_res [2:0]
  output logic [2:0]                           m_tuser,
  output logic                                 m_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [sblc_pkg::TOTAL_W-1:0]    cfg_data
);
  import sblc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIND, ST_FIND_DONE, ST_CLR_CHK, ST_CLR_SCAN, ST_CLR_EVICT,
    ST_INS_SCAN, ST_INS_EVICT, ST_INS_WRITE
  } state_t;

  localparam logic [IDX_W:0] SCAN_END = (IDX_W+1)'(ENTRIES);

  state_t state;

  logic [TOTAL_W-1:0] byte_limit;
  logic               cache_enabled;
  logic               unlimited;

  logic [ENTRIES-1:0] valid;
  logic [STAMP_W-1:0] use_clock;
  logic [TOTAL_W-1:0] total;

  // Table storage
  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic [SIZE_W-1:0]  size_mem [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [KEY_W-1:0]   rd_key;
  logic [SIZE_W-1:0]  rd_size;
  logic [STAMP_W-1:0] rd_stamp;

  // Latched transaction
  logic [1:0]         op;
  logic [KEY_W-1:0]   key;
  logic [SIZE_W-1:0]  size;
  logic [TOTAL_W-1:0] target;
  logic               cont_ins;

  // Scan state
  logic [IDX_W:0]     scan_idx;
  logic               proc_vld;
  logic [IDX_W-1:0]   proc_idx;
  logic               found;
  logic [IDX_W-1:0]   fidx;
  logic [SIZE_W-1:0]  fsize;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               best_found;
  logic [IDX_W-1:0]   best_idx;
  logic [STAMP_W-1:0] best_age;
  logic [KEY_W-1:0]   best_key;
  logic [SIZE_W-1:0]  best_size;
  logic [IDX_W-1:0]   wr_idx;

  // Output register
  logic [KEY_W-1:0]   out_key;
  logic [SIZE_W-1:0]  out_size;
  logic [TOTAL_W-1:0] out_total;

  // Memory port controls
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               kv_we;
  logic               stamp_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [STAMP_W-1:0] use_clock_next;

  logic               can_emit;
  logic [TOTAL_W-1:0] limit;
  logic [STAMP_W-1:0] age;
  logic [TOTAL_W-1:0] drop_f;
  logic [TOTAL_W-1:0] drop_b;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_add;
  logic [ENTRIES-1:0] valid_left;
  logic               scan_busy;
  logic               scan_done;

  assign can_emit = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign limit = cache_enabled ? byte_limit : '0;
  assign age = use_clock - rd_stamp;
  assign use_clock_next = use_clock + 1'b1;
  assign drop_f = (TOTAL_W'(fsize) >= total) ? '0 : total - TOTAL_W'(fsize);
  assign drop_b = (TOTAL_W'(best_size) >= total) ? '0 : total - TOTAL_W'(best_size);
  assign sum = {1'b0, total} + (TOTAL_W+1)'(size);
  assign total_add = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign valid_left = valid & ~(ENTRIES'(1) << best_idx);
  assign scan_busy = (state == ST_FIND) || (state == ST_CLR_SCAN) || (state == ST_INS_SCAN);
  assign scan_done = (scan_idx == SCAN_END) && !proc_vld;

  assign m_tdata = {1'b0, out_total, out_size, out_key};

  // Drive table read and write ports
  always_comb begin
    rd_en = scan_busy && (scan_idx < SCAN_END);
    rd_addr = scan_idx[IDX_W-1:0];
    kv_we = 1'b0;
    stamp_we = 1'b0;
    wr_addr = wr_idx;
    if (state == ST_FIND_DONE && can_emit && op == OP_ADD && found) begin
      stamp_we = 1'b1;
      wr_addr = fidx;
    end else if (state == ST_INS_WRITE && can_emit) begin
      kv_we = 1'b1;
      stamp_we = 1'b1;
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[wr_addr] <= key;
      size_mem[wr_addr] <= size;
    end
    if (stamp_we) begin
      stamp_mem[wr_addr] <= use_clock_next;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_size <= size_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      byte_limit <= '0;
      cache_enabled <= 1'b1;
      unlimited <= 1'b0;
      valid <= '0;
      use_clock <= '0;
      total <= '0;
      m_tvalid <= 1'b0;
      proc_vld <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_BYTE_LIMIT:    byte_limit <= cfg_data;
          REG_CACHE_ENABLED: cache_enabled <= cfg_data[0];
          REG_UNLIMITED:     unlimited <= cfg_data[0];
          default: ;
        endcase
      end

      if (m_tready) m_tvalid <= 1'b0;

      // Advance the shared scan
      if (scan_busy) begin
        if (scan_idx < SCAN_END) begin
          scan_idx <= scan_idx + 1'b1;
          proc_idx <= scan_idx[IDX_W-1:0];
          proc_vld <= 1'b1;
        end else begin
          proc_vld <= 1'b0;
        end
        if (proc_vld) begin
          if (state == ST_FIND) begin
            if (valid[proc_idx] && rd_key == key) begin
              found <= 1'b1;
              fidx <= proc_idx;
              fsize <= rd_size;
            end
          end else if (!valid[proc_idx]) begin
            if (!free_found) begin
              free_found <= 1'b1;
              free_idx <= proc_idx;
            end
          end else if (!best_found || age > best_age) begin
            best_found <= 1'b1;
            best_idx <= proc_idx;
            best_age <= age;
            best_key <= rd_key;
            best_size <= rd_size;
          end
        end
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser;
            key <= s_tdata[KEY_W-1:0];
            size <= s_tdata[KEY_W+SIZE_W-1:KEY_W];
            found <= 1'b0;
            scan_idx <= '0;
            proc_vld <= 1'b0;
            cont_ins <= 1'b0;
            if (s_tuser == OP_ADD || s_tuser == OP_REMOVE) begin
              state <= ST_FIND;
            end else if (s_tuser == OP_TRIM && !unlimited) begin
              target <= limit;
              state <= ST_CLR_CHK;
            end
          end
        end

        ST_FIND: begin
          if (scan_done) state <= ST_FIND_DONE;
        end

        ST_FIND_DONE: begin
          if (can_emit) begin
            out_key <= key;
            m_tlast <= 1'b1;
            state <= ST_IDLE;
            if (op == OP_ADD && found) begin
              use_clock <= use_clock_next;
              m_tvalid <= 1'b1;
              m_tuser <= EV_REFRESHED;
              out_size <= fsize;
              out_total <= total;
            end else if (found) begin
              valid[fidx] <= 1'b0;
              total <= drop_f;
              m_tvalid <= 1'b1;
              m_tuser <= EV_REMOVED;
              out_size <= fsize;
              out_total <= drop_f;
            end else if (op == OP_REMOVE) begin
              m_tvalid <= 1'b1;
              m_tuser <= EV_NOT_FOUND;
              out_size <= '0;
              out_total <= total;
            end else if (!unlimited && TOTAL_W'(size) > limit) begin
              m_tvalid <= 1'b1;
              m_tuser <= EV_REJECTED;
              out_size <= size;
              out_total <= total;
            end else if (!unlimited) begin
              target <= limit - TOTAL_W'(size);
              cont_ins <= 1'b1;
              state <= ST_CLR_CHK;
            end else begin
              scan_idx <= '0;
              free_found <= 1'b0;
              best_found <= 1'b0;
              state <= ST_INS_SCAN;
            end
          end
        end

        ST_CLR_CHK: begin
          scan_idx <= '0;
          proc_vld <= 1'b0;
          free_found <= 1'b0;
          best_found <= 1'b0;
          if (target == '0) begin
            // Flush the whole table and report it with an EV_FLUSHED event
            if (can_emit) begin
              valid <= '0;
              total <= '0;
              m_tvalid <= 1'b1;
              m_tuser <= EV_FLUSHED;
              out_key <= '0;
              out_size <= '0;
              out_total <= '0;
              m_tlast <= !cont_ins;
              state <= cont_ins ? ST_INS_SCAN : ST_IDLE;
            end
          end else if (total > target) begin
            state <= ST_CLR_SCAN;
          end else begin
            state <= cont_ins ? ST_INS_SCAN : ST_IDLE;
          end
        end

        ST_CLR_SCAN: begin
          if (scan_done) state <= ST_CLR_EVICT;
        end

        ST_CLR_EVICT: begin
          scan_idx <= '0;
          proc_vld <= 1'b0;
          free_found <= 1'b0;
          best_found <= 1'b0;
          if (!best_found) begin
            total <= '0;
            state <= cont_ins ? ST_INS_SCAN : ST_IDLE;
          end else if (can_emit) begin
            valid[best_idx] <= 1'b0;
            m_tvalid <= 1'b1;
            m_tuser <= EV_EVICTED;
            out_key <= best_key;
            out_size <= best_size;
            out_total <= drop_b;
            if (drop_b > target && valid_left != '0) begin
              total <= drop_b;
              m_tlast <= 1'b0;
              state <= ST_CLR_SCAN;
            end else begin
              total <= (drop_b > target) ? '0 : drop_b;
              m_tlast <= !cont_ins;
              state <= cont_ins ? ST_INS_SCAN : ST_IDLE;
            end
          end
        end

        ST_INS_SCAN: begin
          if (scan_done) begin
            if (free_found) begin
              wr_idx <= free_idx;
              state <= ST_INS_WRITE;
            end else if (best_found) begin
              state <= ST_INS_EVICT;
            end else begin
              wr_idx <= '0;
              state <= ST_INS_WRITE;
            end
          end
        end

        ST_INS_EVICT: begin
          if (can_emit) begin
            valid[best_idx] <= 1'b0;
            total <= drop_b;
            wr_idx <= best_idx;
            m_tvalid <= 1'b1;
            m_tuser <= EV_EVICTED;
            out_key <= best_key;
            out_size <= best_size;
            out_total <= drop_b;
            m_tlast <= 1'b0;
            state <= ST_INS_WRITE;
          end
        end

        ST_INS_WRITE: begin
          if (can_emit) begin
            valid[wr_idx] <= 1'b1;
            use_clock <= use_clock_next;
            total <= total_add;
            m_tvalid <= 1'b1;
            m_tuser <= EV_ADDED;
            out_key <= key;
            out_size <= size;
            out_total <= total_add;
            m_tlast <= 1'b1;
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `SBLC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready && (s_tuser == OP_ADD || s_tuser == OP_REMOVE), !s_tready)
  `SBLC_ASSERT_IMPL(a_flush_zero_total, m_tvalid && m_tuser == EV_FLUSHED, out_total == '0)
  `SBLC_ASSERT_IMPL(a_added_is_last, m_tvalid && m_tuser == EV_ADDED, m_tlast)

endmodule
`default_nettype wire
